// File: rtl/core/sustain_pedal_note_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// Sustain pedal note tracker - assertion macros
// Shared concurrent assertion forms for the tracker checkers.
// ----------------------------------------------------------------------------
`ifndef SUSTAIN_PEDAL_NOTE_TRACKER_CORE_DEFINES_SVH
`define SUSTAIN_PEDAL_NOTE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define SPTRK_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPTRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sptrk_pkg.sv
// ----------------------------------------------------------------------------
// Sustain pedal note tracker - package
// Field widths, opcodes, controller numbers, FSM states and shared types.
// ----------------------------------------------------------------------------
package sptrk_pkg;

    localparam int OP_W         = 2;
    localparam int CH_FIELD_W   = 4;
    localparam int KEY_FIELD_W  = 7;
    localparam int CC_W         = 7;
    localparam int LVL_W        = 7;
    localparam int VOICES_W     = 4;
    localparam int TOT_W        = 12;

    localparam int CHANNELS_DEF  = 16;
    localparam int KEYS_DEF      = 128;
    localparam int VOICE_CAP_DEF = 9;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON   = 2'd0,
        OP_NOTE_OFF  = 2'd1,
        OP_CTRL      = 2'd2,
        OP_RESET_ALL = 2'd3
    } op_t;

    localparam logic [CC_W-1:0]  CC_PEDAL      = 7'd64;
    localparam logic [CC_W-1:0]  CC_SOUND_OFF  = 7'd120;
    localparam logic [CC_W-1:0]  CC_RESET_CTRL = 7'd121;
    localparam logic [CC_W-1:0]  CC_NOTES_OFF  = 7'd123;
    localparam logic [LVL_W-1:0] PEDAL_THRESH  = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        op_t                    opcode;
        logic [CH_FIELD_W-1:0]  channel;
        logic [KEY_FIELD_W-1:0] key;
        logic [CC_W-1:0]        controller;
        logic [LVL_W-1:0]       level;
    } item_t;

endpackage

// File: rtl/core/sptrk_in_if.sv
// ----------------------------------------------------------------------------
// Sustain pedal note tracker - input channel
// Valid/ready channel carrying one MIDI event per beat.
// ----------------------------------------------------------------------------
interface sptrk_in_if
    import sptrk_pkg::*;
();

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        opcode;
    logic [CH_FIELD_W-1:0]  channel;
    logic [KEY_FIELD_W-1:0] key;
    logic [CC_W-1:0]        controller;
    logic [LVL_W-1:0]       level;

    modport source (
        output valid, opcode, channel, key, controller, level,
        input  ready
    );

    modport sink (
        input  valid, opcode, channel, key, controller, level,
        output ready
    );

    modport mon (
        input valid, ready, opcode, channel, key, controller, level
    );

endinterface

// File: rtl/core/sptrk_out_if.sv
// ----------------------------------------------------------------------------
// Sustain pedal note tracker - result channel
// Valid/ready channel carrying one status beat per event.
// ----------------------------------------------------------------------------
interface sptrk_out_if
    import sptrk_pkg::*;
();

    logic                valid;
    logic                ready;
    logic                key_sounding;
    logic                pedal_down;
    logic [VOICES_W-1:0] active_voices;

    modport source (
        output valid, key_sounding, pedal_down, active_voices,
        input  ready
    );

    modport sink (
        input  valid, key_sounding, pedal_down, active_voices,
        output ready
    );

    modport mon (
        input valid, ready, key_sounding, pedal_down, active_voices
    );

endinterface

// File: rtl/core/sptrk_update.sv
// ----------------------------------------------------------------------------
// Sustain pedal note tracker - channel row update
// Next held/sounding words and their counts for one channel row.
// ----------------------------------------------------------------------------
module sptrk_update
    import sptrk_pkg::*;
#(
    parameter int KEYS  = KEYS_DEF,
    parameter int CNT_W = $clog2(KEYS_DEF + 1)
)
(
    input  item_t             item,
    input  logic              pedal,
    input  logic [KEYS-1:0]   snd,
    input  logic [KEYS-1:0]   hld,
    input  logic [CNT_W-1:0]  cnt_s,
    input  logic [CNT_W-1:0]  cnt_sh,
    output logic [KEYS-1:0]   snd_new,
    output logic [KEYS-1:0]   hld_new,
    output logic [CNT_W-1:0]  cnt_s_new,
    output logic [CNT_W-1:0]  cnt_sh_new,
    output logic              pedal_new,
    output logic              key_sounding
);

    localparam int KEY_W = $clog2(KEYS);

    logic [KEY_W-1:0] kidx;
    logic             key_ok;
    logic             s_b;
    logic             h_b;
    logic             is_on;

    assign kidx   = item.key[KEY_W-1:0];
    assign key_ok = {1'b0, item.key} < (KEY_FIELD_W + 1)'(KEYS);
    assign s_b    = key_ok && snd[kidx];
    assign h_b    = key_ok && hld[kidx];
    assign is_on  = (item.opcode == OP_NOTE_ON) && (item.level != '0);

    // cnt_s tracks popcount(snd), cnt_sh tracks popcount(snd & hld)
    always_comb
    begin
        snd_new    = snd;
        hld_new    = hld;
        cnt_s_new  = cnt_s;
        cnt_sh_new = cnt_sh;
        pedal_new  = pedal;
        case (item.opcode) inside
            OP_NOTE_ON, OP_NOTE_OFF:
            begin
                if (key_ok)
                begin
                    if (is_on)
                    begin
                        snd_new[kidx] = 1'b1;
                        hld_new[kidx] = 1'b1;
                        if (!s_b)
                        begin
                            cnt_s_new = cnt_s + CNT_W'(1);
                        end
                        if (!(s_b && h_b))
                        begin
                            cnt_sh_new = cnt_sh + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        hld_new[kidx] = 1'b0;
                        if (s_b && h_b)
                        begin
                            cnt_sh_new = cnt_sh - CNT_W'(1);
                        end
                        if (!pedal)
                        begin
                            snd_new[kidx] = 1'b0;
                            if (s_b)
                            begin
                                cnt_s_new = cnt_s - CNT_W'(1);
                            end
                        end
                    end
                end
            end
            OP_CTRL:
            begin
                unique case (item.controller)
                    CC_PEDAL:
                    begin
                        pedal_new = item.level >= PEDAL_THRESH;
                        if (!pedal_new)
                        begin
                            snd_new   = snd & hld;
                            cnt_s_new = cnt_sh;
                        end
                    end
                    CC_RESET_CTRL:
                    begin
                        pedal_new = 1'b0;
                        snd_new   = snd & hld;
                        cnt_s_new = cnt_sh;
                    end
                    CC_NOTES_OFF:
                    begin
                        hld_new    = '0;
                        cnt_sh_new = '0;
                        if (!pedal)
                        begin
                            snd_new   = '0;
                            cnt_s_new = '0;
                        end
                    end
                    CC_SOUND_OFF:
                    begin
                        hld_new    = '0;
                        snd_new    = '0;
                        cnt_sh_new = '0;
                        cnt_s_new  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign key_sounding = key_ok && snd_new[kidx];

endmodule

// File: rtl/core/sustain_pedal_note_tracker_core.sv
// ----------------------------------------------------------------------------
// Sustain pedal note tracker core
// Per-channel held/sounding key bits and sustain pedal state for MIDI events.
// item:   one event per beat (opcode, channel, key, controller, level).
// result: one beat per event: key_sounding and pedal_down of the addressed
//         channel/key after the event, active_voices capped at VOICE_CAP.
// Each event first reads its channel row synchronously (held bits, sounding
// bits and their counts), then modifies it and writes it back. One event is
// in flight; the result leaves through an output register, so a new event is
// taken while the previous result still waits.
// If the receiver stalls, the event behind it holds in the modify cycle until
// the output register frees up.
// Reset clears all rows at once through per-row valid flops, plus the pedal
// bits and the running total; no clearing pass. Reset-all events do the same.
// ----------------------------------------------------------------------------
module sustain_pedal_note_tracker_core
    import sptrk_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int KEYS      = KEYS_DEF,
    parameter int VOICE_CAP = VOICE_CAP_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    sptrk_in_if.sink     item,
    sptrk_out_if.source  result
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(KEYS + 1);
    localparam int ROW_W = 2 * KEYS + 2 * CNT_W;

    state_t              state_reg;
    state_t              state_next;
    item_t               item_reg;
    logic [ROW_W-1:0]    mem [CHANNELS];
    logic [ROW_W-1:0]    rdata_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic [CHANNELS-1:0] pedal_reg;
    logic [TOT_W-1:0]    total_reg;
    logic                out_valid_reg;
    logic                key_sounding_reg;
    logic                pedal_down_reg;
    logic [VOICES_W-1:0] active_voices_reg;

    logic                in_ready;
    logic                accept;
    logic                done;
    logic                ch_ok;
    logic                is_rst;
    logic [CH_W-1:0]     ch_idx;
    logic [CH_W-1:0]     rd_idx;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    row_new;
    logic                pedal_cur;
    logic                mem_we;

    logic [KEYS-1:0]     snd;
    logic [KEYS-1:0]     hld;
    logic [CNT_W-1:0]    cnt_s;
    logic [CNT_W-1:0]    cnt_sh;
    logic [KEYS-1:0]     snd_new;
    logic [KEYS-1:0]     hld_new;
    logic [CNT_W-1:0]    cnt_s_new;
    logic [CNT_W-1:0]    cnt_sh_new;
    logic                pedal_new;
    logic                ks_upd;

    logic [TOT_W-1:0]    total_upd;
    logic [TOT_W-1:0]    total_n;
    logic [TOT_W-1:0]    voices_cap;
    logic                ks_n;
    logic                pd_n;

    // ---- FSM ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                done = !out_valid_reg || result.ready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept     = item.valid && in_ready;
    assign item.ready = in_ready;

    // ---- row access ----
    assign ch_ok     = {1'b0, item_reg.channel} < (CH_FIELD_W + 1)'(CHANNELS);
    assign ch_idx    = item_reg.channel[CH_W-1:0];
    assign rd_idx    = (state_reg == ST_IDLE) ? item.channel[CH_W-1:0] : ch_idx;
    assign is_rst    = item_reg.opcode == OP_RESET_ALL;
    assign row       = (ch_ok && valid_reg[ch_idx]) ? rdata_reg : '0;
    assign pedal_cur = ch_ok && pedal_reg[ch_idx];
    assign {snd, hld, cnt_s, cnt_sh} = row;
    assign row_new   = {snd_new, hld_new, cnt_s_new, cnt_sh_new};
    assign mem_we    = done && ch_ok && !is_rst;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ch_idx] <= row_new;
        end
        rdata_reg <= mem[rd_idx];
    end

    sptrk_update #(
        .KEYS  (KEYS),
        .CNT_W (CNT_W)
    ) u_sptrk_update (
        .item         (item_reg),
        .pedal        (pedal_cur),
        .snd          (snd),
        .hld          (hld),
        .cnt_s        (cnt_s),
        .cnt_sh       (cnt_sh),
        .snd_new      (snd_new),
        .hld_new      (hld_new),
        .cnt_s_new    (cnt_s_new),
        .cnt_sh_new   (cnt_sh_new),
        .pedal_new    (pedal_new),
        .key_sounding (ks_upd)
    );

    // ---- result ----
    assign total_upd = total_reg - TOT_W'(cnt_s) + TOT_W'(cnt_s_new);

    always_comb
    begin
        if (is_rst)
        begin
            total_n = '0;
            ks_n    = 1'b0;
            pd_n    = 1'b0;
        end
        else if (!ch_ok)
        begin
            total_n = total_reg;
            ks_n    = 1'b0;
            pd_n    = 1'b0;
        end
        else
        begin
            total_n = total_upd;
            ks_n    = ks_upd;
            pd_n    = pedal_new;
        end
    end

    assign voices_cap = (total_n > TOT_W'(VOICE_CAP)) ? TOT_W'(VOICE_CAP) : total_n;

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            pedal_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_n;
                if (is_rst)
                begin
                    valid_reg <= '0;
                    pedal_reg <= '0;
                end
                else if (ch_ok)
                begin
                    valid_reg[ch_idx] <= 1'b1;
                    pedal_reg[ch_idx] <= pedal_new;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode     <= op_t'(item.opcode);
            item_reg.channel    <= item.channel;
            item_reg.key        <= item.key;
            item_reg.controller <= item.controller;
            item_reg.level      <= item.level;
        end
        if (done)
        begin
            key_sounding_reg  <= ks_n;
            pedal_down_reg    <= pd_n;
            active_voices_reg <= voices_cap[VOICES_W-1:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.key_sounding  = key_sounding_reg;
    assign result.pedal_down    = pedal_down_reg;
    assign result.active_voices = active_voices_reg;

endmodule

// File: rtl/core/sptrk_checker.sv
// ----------------------------------------------------------------------------
// Sustain pedal note tracker - port checker
// Timing and range checks on the tracker's channels, bound to the core.
// ----------------------------------------------------------------------------
`include "sustain_pedal_note_tracker_core_defines.svh"

module sptrk_checker
    import sptrk_pkg::*;
#(
    parameter int VOICE_CAP = VOICE_CAP_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic                key_sounding,
    input logic                pedal_down,
    input logic [VOICES_W-1:0] active_voices
);

    logic                item_fire;
    logic                out_stall;
    logic [VOICES_W+1:0] payload;

    assign item_fire = item_valid && item_ready;
    assign out_stall = result_valid && !result_ready;
    assign payload   = {key_sounding, pedal_down, active_voices};

    // one event in flight
    `SPTRK_ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_fire, !item_ready, "busy accept")

    // a fresh result follows its event through the EXEC state and the output register
    `SPTRK_ASSERT_SAME(a_latency, clk, rst_n, $rose(result_valid), $past(item_fire, 2), "no event")

    `SPTRK_ASSERT_SAME(a_cap, clk, rst_n, result_valid, int'(active_voices) <= VOICE_CAP, "cap")

    `SPTRK_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, result_valid && $stable(payload), "moved")

endmodule

bind sustain_pedal_note_tracker_core sptrk_checker #(
    .VOICE_CAP (VOICE_CAP)
) u_sptrk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .key_sounding  (result.key_sounding),
    .pedal_down    (result.pedal_down),
    .active_voices (result.active_voices)
);
